FILE: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

  // Word format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Derived widths
  localparam int DW  = 2 * WORD_BITS + 2;   // discriminant
  localparam int SW  = WORD_BITS + 1;       // square root, one bit per cell
  localparam int RW  = SW + 2;              // square root remainder
  localparam int NW  = WORD_BITS + 2;       // numerator magnitude
  localparam int DDW = WORD_BITS + 1;       // divisor and divider remainder
  localparam int NFW = NW + FRAC_BITS;      // scaled numerator

  // Result classes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_ONE   = 3'd1;
  localparam logic [2:0] CLS_TWO   = 3'd2;
  localparam logic [2:0] CLS_INF   = 3'd3;
  localparam logic [2:0] CLS_NOSOL = 3'd4;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Sign/magnitude coefficients plus class so far
  typedef struct packed {
    logic                 na;
    logic                 nb;
    logic                 nc;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic [WORD_BITS-1:0] mc;
    logic [2:0]           cls;
    logic                 quad;
  } coef_t;

  typedef struct packed {
    logic [DW-1:0] rad;
    logic [RW-1:0] rem;
    logic [SW-1:0] root;
    coef_t         coef;
  } sqrt_t;

  // One divider lane: sh holds the remaining numerator bits and collects quotient bits
  typedef struct packed {
    logic [DDW-1:0]       rem;
    logic [WORD_BITS-1:0] sh;
    logic [DDW-1:0]       den;
    logic                 neg;
    logic                 ovf;
    logic                 use_q;
  } lane_t;

  typedef struct packed {
    lane_t      l1;
    lane_t      l2;
    logic [2:0] cls;
  } div_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] root;
    logic                 sat;
  } res_t;

  // One digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t x);
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    sqrt_t         y;
    y     = x;
    t     = {x.rem, x.rad[DW-1:DW-2]};
    trial = {2'b00, x.root, 2'b01};
    if (t >= trial) begin
      t      = t - trial;
      y.root = {x.root[SW-2:0], 1'b1};
    end else begin
      y.root = {x.root[SW-2:0], 1'b0};
    end
    y.rem = t[RW-1:0];
    y.rad = {x.rad[DW-3:0], 2'b00};
    return y;
  endfunction

  // One quotient bit of the restoring divider
  function automatic lane_t div_step(lane_t x);
    logic [DDW:0] t;
    logic         qb;
    lane_t        y;
    y  = x;
    t  = {x.rem, x.sh[WORD_BITS-1]};
    qb = 1'b0;
    if (t >= {1'b0, x.den}) begin
      t  = t - {1'b0, x.den};
      qb = 1'b1;
    end
    y.rem = t[DDW-1:0];
    y.sh  = {x.sh[WORD_BITS-2:0], qb};
    return y;
  endfunction

  // Load a lane: scale numerator, catch quotients of more than WORD_BITS bits
  function automatic lane_t mk_lane(logic [NW-1:0] mag, logic neg, logic [DDW-1:0] den,
                                    logic use_q);
    logic [NFW-1:0] num;
    logic [NFW-1:0] hi;
    lane_t          l;
    num     = {mag, {FRAC_BITS{1'b0}}};
    hi      = num >> WORD_BITS;
    l.rem   = hi[DDW-1:0];
    l.sh    = num[WORD_BITS-1:0];
    l.den   = den;
    l.neg   = neg;
    l.use_q = use_q;
    l.ovf   = hi >= {{(NFW-DDW){1'b0}}, den};
    return l;
  endfunction

  // Clip, apply sign, zero an unused lane
  function automatic res_t fin_lane(lane_t l);
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] q;
    logic                 sat;
    res_t                 r;
    lim = l.neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    sat = l.ovf || (l.sh > lim);
    q   = sat ? lim : l.sh;
    r.root = !l.use_q ? '0 : (l.neg ? (~q + 1'b1) : q);
    r.sat  = l.use_q && sat;
    return r;
  endfunction

endpackage

FILE: hw/rtl/qrs_if.sv
`timescale 1ns / 1ps

interface qrs_in_if;
  logic          valid;
  logic          ready;
  qrs_pkg::word_t coef_a;
  qrs_pkg::word_t coef_b;
  qrs_pkg::word_t coef_c;
  modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
  logic          valid;
  logic          ready;
  logic [2:0]    root_class;
  qrs_pkg::word_t root_first;
  qrs_pkg::word_t root_second;
  logic          saturated;
  modport source(output valid, output root_class, output root_first, output root_second,
                 output saturated, input ready);
  modport sink(input valid, input root_class, input root_first, input root_second,
               input saturated, output ready);
endinterface

FILE: hw/rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps

module qrs_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  qrs_pkg::sqrt_t in_data,
  output logic           out_valid,
  output qrs_pkg::sqrt_t out_data
);

  logic           valid_r;
  qrs_pkg::sqrt_t data_r;
  qrs_pkg::sqrt_t data_nxt;

  // one root bit per cell
  assign data_nxt = qrs_pkg::sqrt_step(in_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/qrs_div_cell.sv
`timescale 1ns / 1ps

module qrs_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::div_t in_data,
  output logic          out_valid,
  output qrs_pkg::div_t out_data
);

  logic          valid_r;
  qrs_pkg::div_t data_r;
  qrs_pkg::div_t data_nxt;

  // one quotient bit per lane per cell
  always_comb begin
    data_nxt     = in_data;
    data_nxt.l1  = qrs_pkg::div_step(in_data.l1);
    data_nxt.l2  = qrs_pkg::div_step(in_data.l2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; a WORD_BITS+1 cell square root row and a
// WORD_BITS cell two-lane divider row each retire one bit per cell per cycle.
// A stalled output freezes the whole pipeline; input ready follows it.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.

module quadratic_root_solver (
  input logic         clk,
  input logic         rst_n,
  qrs_in_if.sink      in_if,
  qrs_out_if.source   out_if
);

  localparam int W  = qrs_pkg::WORD_BITS;
  localparam int SW = qrs_pkg::SW;
  localparam int NW = qrs_pkg::NW;

  logic en;
  logic out_valid_r;

  // whole pipe advances unless the output word is held
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Stage A: sign/magnitude split, early class, products
  qrs_pkg::coef_t   a_coef_nxt;
  logic [2*W-1:0]   a_bb_nxt;
  logic [2*W-1:0]   a_ac_nxt;
  logic             a_valid_r;
  qrs_pkg::coef_t   a_coef_r;
  logic [2*W-1:0]   a_bb_r;
  logic [2*W-1:0]   a_ac_r;

  always_comb begin
    a_coef_nxt.na = in_if.coef_a[W-1];
    a_coef_nxt.nb = in_if.coef_b[W-1];
    a_coef_nxt.nc = in_if.coef_c[W-1];
    a_coef_nxt.ma = in_if.coef_a[W-1] ? (~in_if.coef_a + 1'b1) : in_if.coef_a;
    a_coef_nxt.mb = in_if.coef_b[W-1] ? (~in_if.coef_b + 1'b1) : in_if.coef_b;
    a_coef_nxt.mc = in_if.coef_c[W-1] ? (~in_if.coef_c + 1'b1) : in_if.coef_c;
    a_coef_nxt.quad = 1'b0;
    if (a_coef_nxt.ma == '0 && a_coef_nxt.mb == '0 && a_coef_nxt.mc == '0) begin
      a_coef_nxt.cls = qrs_pkg::CLS_INF;
    end else if (a_coef_nxt.ma == '0 && a_coef_nxt.mb == '0) begin
      a_coef_nxt.cls = qrs_pkg::CLS_NOSOL;
    end else if (a_coef_nxt.ma == '0) begin
      a_coef_nxt.cls = qrs_pkg::CLS_ONE;
    end else begin
      a_coef_nxt.cls  = qrs_pkg::CLS_NONE;
      a_coef_nxt.quad = 1'b1;
    end
    a_bb_nxt = {{W{1'b0}}, a_coef_nxt.mb} * {{W{1'b0}}, a_coef_nxt.mb};
    a_ac_nxt = {{W{1'b0}}, a_coef_nxt.ma} * {{W{1'b0}}, a_coef_nxt.mc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_coef_r <= a_coef_nxt;
      a_bb_r   <= a_bb_nxt;
      a_ac_r   <= a_ac_nxt;
    end
  end

  // Stage B: exact discriminant and its sign
  logic [qrs_pkg::DW-1:0] bbx;
  logic [qrs_pkg::DW-1:0] fac;
  logic                   fac_neg;
  logic                   disc_pos;
  logic                   disc_neg;
  qrs_pkg::sqrt_t         b_data_nxt;
  logic                   b_valid_r;
  qrs_pkg::sqrt_t         b_data_r;

  always_comb begin
    bbx      = {2'b00, a_bb_r};
    fac      = {a_ac_r, 2'b00};
    fac_neg  = (a_coef_r.na != a_coef_r.nc) && (fac != '0);
    disc_pos = fac_neg || (bbx > fac);
    disc_neg = !fac_neg && (bbx < fac);
    b_data_nxt.coef = a_coef_r;
    b_data_nxt.rem  = '0;
    b_data_nxt.root = '0;
    if (fac_neg) begin
      b_data_nxt.rad = bbx + fac;
    end else if (disc_pos) begin
      b_data_nxt.rad = bbx - fac;
    end else begin
      b_data_nxt.rad = '0;
    end
    if (a_coef_r.quad) begin
      if (disc_pos) begin
        b_data_nxt.coef.cls = qrs_pkg::CLS_TWO;
      end else if (disc_neg) begin
        b_data_nxt.coef.cls = qrs_pkg::CLS_NONE;
      end else begin
        b_data_nxt.coef.cls = qrs_pkg::CLS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_data_r <= b_data_nxt;
    end
  end

  // Square root row
  logic           sq_valid [SW+1];
  qrs_pkg::sqrt_t sq_data  [SW+1];

  assign sq_valid[0] = b_valid_r;
  assign sq_data[0]  = b_data_r;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_valid[i]),
      .in_data   (sq_data[i]),
      .out_valid (sq_valid[i+1]),
      .out_data  (sq_data[i+1])
    );
  end

  // Stage C: numerators and divisors for both lanes
  qrs_pkg::coef_t   cf;
  logic signed [NW:0] nbv;
  logic signed [NW:0] sx;
  logic signed [NW:0] tp;
  logic signed [NW:0] tm;
  logic signed [NW:0] tp_abs;
  logic signed [NW:0] tm_abs;
  logic [NW-1:0]    mp;
  logic [NW-1:0]    mm;
  logic [NW-1:0]    mbx;
  logic [NW-1:0]    mcx;
  qrs_pkg::div_t    c_data_nxt;
  logic             c_valid_r;
  qrs_pkg::div_t    c_data_r;

  always_comb begin
    cf     = sq_data[SW].coef;
    nbv    = cf.nb ? $signed({3'b000, cf.mb}) : -$signed({3'b000, cf.mb});
    sx     = $signed({2'b00, sq_data[SW].root});
    tp     = nbv + sx;
    tm     = nbv - sx;
    tp_abs = tp[NW] ? -tp : tp;
    tm_abs = tm[NW] ? -tm : tm;
    mp     = tp_abs[NW-1:0];
    mm     = tm_abs[NW-1:0];
    mbx    = {2'b00, cf.mb};
    mcx    = {2'b00, cf.mc};
    c_data_nxt.cls = cf.cls;
    c_data_nxt.l1  = qrs_pkg::mk_lane('0, 1'b0, '0, 1'b0);
    c_data_nxt.l2  = qrs_pkg::mk_lane('0, 1'b0, '0, 1'b0);
    if (cf.quad && cf.cls == qrs_pkg::CLS_TWO) begin
      c_data_nxt.l1 = qrs_pkg::mk_lane(mp, (mp != '0) && (tp[NW] != cf.na),
                                       {cf.ma, 1'b0}, 1'b1);
      c_data_nxt.l2 = qrs_pkg::mk_lane(mm, (mm != '0) && (tm[NW] != cf.na),
                                       {cf.ma, 1'b0}, 1'b1);
    end else if (cf.quad && cf.cls == qrs_pkg::CLS_ONE) begin
      // double root -b/2a
      c_data_nxt.l1 = qrs_pkg::mk_lane(mbx, (cf.mb != '0) && (cf.nb == cf.na),
                                       {cf.ma, 1'b0}, 1'b1);
    end else if (!cf.quad && cf.cls == qrs_pkg::CLS_ONE) begin
      // linear root -c/b
      c_data_nxt.l1 = qrs_pkg::mk_lane(mcx, (cf.mc != '0) && (cf.nc == cf.nb),
                                       {1'b0, cf.mb}, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= sq_valid[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_data_r <= c_data_nxt;
    end
  end

  // Divider row
  logic          dv_valid [W+1];
  qrs_pkg::div_t dv_data  [W+1];

  assign dv_valid[0] = c_valid_r;
  assign dv_data[0]  = c_data_r;

  for (genvar j = 0; j < W; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_valid[j]),
      .in_data   (dv_data[j]),
      .out_valid (dv_valid[j+1]),
      .out_data  (dv_data[j+1])
    );
  end

  // Output register: clip, sign, flag
  qrs_pkg::res_t r1;
  qrs_pkg::res_t r2;
  logic [2:0]    out_cls_r;
  logic [W-1:0]  out_r1_r;
  logic [W-1:0]  out_r2_r;
  logic          out_sat_r;

  assign r1 = qrs_pkg::fin_lane(dv_data[W].l1);
  assign r2 = qrs_pkg::fin_lane(dv_data[W].l2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cls_r <= dv_data[W].cls;
      out_r1_r  <= r1.root;
      out_r2_r  <= r2.root;
      out_sat_r <= r1.sat || r2.sat;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.root_class  = out_cls_r;
  assign out_if.root_first  = out_r1_r;
  assign out_if.root_second = out_r2_r;
  assign out_if.saturated   = out_sat_r;

`ifndef SYNTH
  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.root_class <= qrs_pkg::CLS_NOSOL)
    else $error("root class out of range");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.root_class != qrs_pkg::CLS_TWO |-> out_if.root_second == '0)
    else $error("second root set without two roots");

  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.root_class == qrs_pkg::CLS_NONE ||
                     out_if.root_class == qrs_pkg::CLS_INF ||
                     out_if.root_class == qrs_pkg::CLS_NOSOL)
    |-> out_if.root_first == '0 && !out_if.saturated)
    else $error("root or flag set for a rootless class");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |=> $stable(c_valid_r) && $stable(b_valid_r))
    else $error("pipeline moved during a stall");
`endif

endmodule
